/* hdl/tmsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_pkg
// Shared constants, record codes and record types for the tracker module
// stream parser.
// ----------------------------------------------------------------------------
package tmsp_pkg;

  // File layout
  localparam int SAMPLE_SLOTS     = 31;
  localparam int ORDER_ENTRIES    = 128;
  localparam int ROWS_PER_PATTERN = 64;
  localparam int CHANNELS         = 4;
  localparam int NAME_BYTES       = 20;
  localparam int HEADER_BYTES     = 30;
  localparam int HEADER_NAME      = 22;
  localparam int NOTE_BYTES       = 4;
  localparam int TAG_BYTES        = (SAMPLE_SLOTS == 31) ? 4 : 0;

  localparam int POS_W  = 19;
  localparam int HOFF_W = 5;
  localparam int SLOT_W = 5;
  localparam int HELD_N = 7;

  localparam int NOTE_SHIFT    = $clog2(NOTE_BYTES);
  localparam int CH_W          = $clog2(CHANNELS);
  localparam int ROW_W         = $clog2(ROWS_PER_PATTERN);
  localparam int PATTERN_SHIFT = NOTE_SHIFT + CH_W + ROW_W;

  localparam logic [POS_W-1:0] NAME_END      = POS_W'(NAME_BYTES);
  localparam logic [POS_W-1:0] SAMPLES_END   = POS_W'(NAME_BYTES + HEADER_BYTES * SAMPLE_SLOTS);
  localparam logic [POS_W-1:0] ORDERS_START  = POS_W'(NAME_BYTES + HEADER_BYTES * SAMPLE_SLOTS
                                                      + 2);
  localparam logic [POS_W-1:0] ORDERS_END    = POS_W'(NAME_BYTES + HEADER_BYTES * SAMPLE_SLOTS
                                                      + 2 + ORDER_ENTRIES);
  localparam logic [POS_W-1:0] PATTERN_START = POS_W'(NAME_BYTES + HEADER_BYTES * SAMPLE_SLOTS
                                                      + 2 + ORDER_ENTRIES + TAG_BYTES);

  localparam logic [HOFF_W-1:0] HOFF_NAME_END = HOFF_W'(HEADER_NAME);
  localparam logic [HOFF_W-1:0] HOFF_LAST     = HOFF_W'(HEADER_BYTES - 1);
  localparam logic [7:0]        ORDER_LAST    = 8'(ORDER_ENTRIES - 1);

  // Record kinds
  localparam logic [2:0] KIND_SAMPLE     = 3'd0;
  localparam logic [2:0] KIND_SONG_LEN   = 3'd1;
  localparam logic [2:0] KIND_ORDER      = 3'd2;
  localparam logic [2:0] KIND_PAT_COUNT  = 3'd3;
  localparam logic [2:0] KIND_NOTE       = 3'd4;
  localparam logic [2:0] KIND_DATA_OFFS  = 3'd5;

  // One result record
  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  item_index;
    logic [5:0]  row_number;
    logic [1:0]  channel_number;
    logic [18:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic        last_result;
  } tmsp_result_t;

  // Records produced by one byte, handed from the parser to the queue
  typedef struct packed {
    logic [1:0]   count;
    tmsp_result_t r0;
    tmsp_result_t r1;
  } tmsp_push_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

/* hdl/tmsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_in_if / tmsp_out_if
// Valid/ready channels for module file bytes and parsed records.
// ----------------------------------------------------------------------------
interface tmsp_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tmsp_out_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [7:0]  item_index;
  logic [5:0]  row_number;
  logic [1:0]  channel_number;
  logic [18:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [7:0]  byte_a;
  logic [7:0]  byte_b;
  logic        last_result;

  modport source (output valid, output record_kind, output item_index, output row_number,
                  output channel_number, output word_a, output word_b, output word_c,
                  output byte_a, output byte_b, output last_result, input ready);
  modport sink   (input valid, input record_kind, input item_index, input row_number,
                  input channel_number, input word_a, input word_b, input word_c,
                  input byte_a, input byte_b, input last_result, output ready);
endinterface

/* hdl/tmsp_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_parse_core
// Input byte register, parse position state and record assembly. Each byte
// is decoded into zero, one or two records.
// ----------------------------------------------------------------------------
module tmsp_parse_core import tmsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tmsp_in_if.sink    in_chan,
  input  logic       room,
  output tmsp_push_t push
);

  // Input register
  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_data_r;
  logic       hold_sof_r;
  logic       in_take, advance;

  assign advance       = hold_v_r & room;
  assign in_chan.ready = !hold_v_r || room;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign hold_v_nxt    = in_take || (hold_v_r && !room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_data_r <= in_chan.data_byte;
      hold_sof_r  <= in_chan.start_of_file;
    end
  end

  // Parse state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [HOFF_W-1:0] hoff_r, hoff_nxt;
  logic [7:0]        largest_r, largest_nxt;
  logic [8:0]        ptotal_r, ptotal_nxt;
  logic              fin_r, fin_nxt;
  logic [7:0]        held_r [HELD_N];

  // State as seen by this byte (start flag clears it first)
  logic [POS_W-1:0]  pos;
  logic [SLOT_W-1:0] slot;
  logic [HOFF_W-1:0] hoff;
  logic [7:0]        largest;
  logic [8:0]        ptotal;
  logic              fin;

  logic [7:0]        d;
  logic              in_hdr, is_len, in_ord, in_pat;
  logic [POS_W-1:0]  rel, ord_rel, pat_bytes;
  logic [7:0]        ord_idx, new_max;
  logic [1:0]        nb;
  logic              held_we;
  logic [2:0]        held_idx;
  logic              pv, sv;
  tmsp_result_t      p, s;

  always_comb begin
    d       = hold_data_r;
    pos     = hold_sof_r ? '0 : pos_r;
    slot    = hold_sof_r ? '0 : slot_r;
    hoff    = hold_sof_r ? '0 : hoff_r;
    largest = hold_sof_r ? '0 : largest_r;
    ptotal  = hold_sof_r ? '0 : ptotal_r;
    fin     = hold_sof_r ? 1'b0 : fin_r;

    in_hdr    = (pos >= NAME_END) && (pos < SAMPLES_END);
    is_len    = (pos == SAMPLES_END);
    in_ord    = (pos >= ORDERS_START) && (pos < ORDERS_END);
    in_pat    = (pos >= PATTERN_START);
    rel       = pos - PATTERN_START;
    ord_rel   = pos - ORDERS_START;
    ord_idx   = ord_rel[7:0];
    nb        = rel[NOTE_SHIFT-1:0];
    pat_bytes = POS_W'({ptotal, {PATTERN_SHIFT{1'b0}}});
    new_max   = (d > largest) ? d : largest;

    pos_nxt     = pos + 1'b1;
    slot_nxt    = slot;
    hoff_nxt    = hoff;
    largest_nxt = largest;
    ptotal_nxt  = ptotal;
    fin_nxt     = fin;
    held_we     = 1'b0;
    held_idx    = '0;
    pv          = 1'b0;
    sv          = 1'b0;
    p           = '0;
    s           = '0;

    if (fin) begin
      pos_nxt = pos;
    end else begin
      // Sample headers: name skipped, 7 bytes held, record on the last byte
      if (in_hdr) begin
        if (hoff == HOFF_LAST) begin
          hoff_nxt = '0;
          slot_nxt = slot + 1'b1;
          pv = 1'b1;
          p.record_kind = KIND_SAMPLE;
          p.item_index  = 8'(slot);
          p.word_a      = 19'({held_r[0], held_r[1], 1'b0});
          p.word_b      = {held_r[4], held_r[5]};
          p.word_c      = {held_r[6], d};
          p.byte_a      = held_r[2];
          p.byte_b      = held_r[3];
        end else begin
          hoff_nxt = hoff + 1'b1;
          if (hoff >= HOFF_NAME_END) begin
            held_we  = 1'b1;
            held_idx = 3'(hoff - HOFF_NAME_END);
          end
        end
      end

      // Song length
      if (is_len) begin
        pv = 1'b1;
        p.record_kind = KIND_SONG_LEN;
        p.word_a      = 19'(d);
      end

      // Order table; pattern count follows the last entry
      if (in_ord) begin
        largest_nxt = new_max;
        pv = 1'b1;
        p.record_kind = KIND_ORDER;
        p.item_index  = ord_idx;
        p.word_a      = 19'(d);
        if (ord_idx == ORDER_LAST) begin
          ptotal_nxt = {1'b0, new_max} + 9'd1;
          sv = 1'b1;
          s.record_kind = KIND_PAT_COUNT;
          s.word_a      = 19'(ptotal_nxt);
        end
      end

      // Pattern notes; data offset after the last pattern byte
      if (in_pat) begin
        if (nb == 2'(NOTE_BYTES - 1)) begin
          pv = 1'b1;
          p.record_kind    = KIND_NOTE;
          p.item_index     = rel[PATTERN_SHIFT+7:PATTERN_SHIFT];
          p.row_number     = rel[PATTERN_SHIFT-1:NOTE_SHIFT+CH_W];
          p.channel_number = rel[NOTE_SHIFT+CH_W-1:NOTE_SHIFT];
          p.word_a         = 19'({held_r[0][3:0], held_r[1]});
          p.word_b         = 16'({held_r[0][7:4], held_r[2][7:4]});
          p.word_c         = 16'(d);
          p.byte_a         = 8'(held_r[2][7:4]);
        end else begin
          held_we  = 1'b1;
          held_idx = 3'(nb);
        end
        if (({1'b0, rel} + 1'b1) >= {1'b0, pat_bytes}) begin
          fin_nxt = 1'b1;
          sv = 1'b1;
          s.record_kind = KIND_DATA_OFFS;
          s.word_a      = PATTERN_START + pat_bytes;
        end
      end
    end

    p.last_result = !sv;
    s.last_result = 1'b1;

    push.count = advance ? (2'(pv) + 2'(sv)) : 2'd0;
    push.r0    = pv ? p : s;
    push.r1    = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      slot_r    <= '0;
      hoff_r    <= '0;
      largest_r <= '0;
      ptotal_r  <= '0;
      fin_r     <= 1'b0;
    end else if (advance) begin
      pos_r     <= pos_nxt;
      slot_r    <= slot_nxt;
      hoff_r    <= hoff_nxt;
      largest_r <= largest_nxt;
      ptotal_r  <= ptotal_nxt;
      fin_r     <= fin_nxt;
    end
  end

  // Held header / note bytes: always written before they are read
  always_ff @(posedge clk) begin
    if (advance && held_we) begin
      held_r[held_idx] <= d;
    end
  end

endmodule

/* hdl/tmsp_result_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_result_queue
// Four-entry shifting record queue. Takes up to two records a cycle and
// presents the oldest one from a register on the output channel.
// ----------------------------------------------------------------------------
module tmsp_result_queue import tmsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tmsp_push_t  push,
  output logic        room,
  tmsp_out_if.source  out_chan
);

  tmsp_result_t      q_r [QUEUE_DEPTH];
  tmsp_result_t      q_nxt [QUEUE_DEPTH];
  tmsp_result_t      shifted [QUEUE_DEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic              pop;

  // Room for a two-record byte, judged before this cycle's pop
  assign room = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop  = (cnt_r != '0) && out_chan.ready;

  // Shift out the head, then append new records behind the survivors
  always_comb begin
    cnt_after = cnt_r - QCNT_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        shifted[i] = q_r[i + 1];
      end else begin
        shifted[i] = q_r[i];
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = shifted[i];
      if ((push.count != 2'd0) && (QCNT_W'(i) == cnt_after)) begin
        q_nxt[i] = push.r0;
      end
      if ((push.count == 2'd2) && (QCNT_W'(i) == cnt_after + 1'b1)) begin
        q_nxt[i] = push.r1;
      end
    end
    cnt_nxt = cnt_after + QCNT_W'(push.count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Head of the queue drives the channel
  assign out_chan.valid          = (cnt_r != '0);
  assign out_chan.record_kind    = q_r[0].record_kind;
  assign out_chan.item_index     = q_r[0].item_index;
  assign out_chan.row_number     = q_r[0].row_number;
  assign out_chan.channel_number = q_r[0].channel_number;
  assign out_chan.word_a         = q_r[0].word_a;
  assign out_chan.word_b         = q_r[0].word_b;
  assign out_chan.word_c         = q_r[0].word_c;
  assign out_chan.byte_a         = q_r[0].byte_a;
  assign out_chan.byte_b         = q_r[0].byte_b;
  assign out_chan.last_result    = q_r[0].last_result;

endmodule

/* hdl/tracker_module_stream_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_module_stream_parser
// Byte-serial parser for four-channel tracker module files.
// ----------------------------------------------------------------------------
// Takes one module byte per cycle on in_chan while ready is high
// (start_of_file marks byte 0 and restarts parsing) and emits sample header,
// song length, order entry, pattern count, note and sample data offset
// records on out_chan, one record per cycle while out_chan is ready, the last
// record of each byte flagged by last_result. A byte is registered, decoded
// from the input register and its records land in a four-entry output queue,
// whose head register presents the first record. Throughput is one byte per
// cycle without back-pressure; the last order byte and the last pattern byte
// each make two records. A new byte is accepted while the input register is
// empty or the queue holds at most two records; the output queue and its
// drain rate set the figure under back-pressure. Bytes after the data offset
// record are taken and dropped until the next start_of_file.
// ----------------------------------------------------------------------------
module tracker_module_stream_parser import tmsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tmsp_in_if.sink    in_chan,
  tmsp_out_if.source out_chan
);

  tmsp_push_t push;
  logic       room;

  tmsp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  tmsp_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

  // Queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("record presented right after reset");

  // Pattern count is always the final record of its byte
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.record_kind == KIND_PAT_COUNT) |-> out_chan.last_result)
    else $error("pattern count not flagged last");

  // Only the last order entry is followed by a second record
  a_order_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.record_kind == KIND_ORDER && out_chan.item_index != ORDER_LAST)
    |-> out_chan.last_result)
    else $error("order entry wrongly followed by a record");

  // Row and channel are only set on note records
  a_note_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.record_kind != KIND_NOTE)
    |-> (out_chan.row_number == '0 && out_chan.channel_number == '0))
    else $error("row or channel set on a non-note record");

endmodule
